// ----- hw/rtl/rsds_pkg.sv -----
// ----------------------------------------------------------------------------
// rsds_pkg: shared types and constants of the reduce-scatter schedule block
// Item layouts, register indexes, request and status codes, default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rsds_pkg;

    localparam int MAX_RANKS_DEF    = 64;
    localparam int RANK_ID_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam int POS_W   = 6;
    localparam int RANK_W  = 16;
    localparam int STEP_W  = 3;
    localparam int CNT_W   = 32;
    localparam int EB_W    = 4;
    localparam int BASE_W  = 48;
    localparam int OFF_W   = 49;
    localparam int BYTES_W = 35;
    localparam int RCNT_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANK_COUNT   = 3'd0,
        CFG_MY_RANK      = 3'd1,
        CFG_SLICE_COUNT  = 3'd2,
        CFG_TAIL_COUNT   = 3'd3,
        CFG_ELEM_BYTES   = 3'd4,
        CFG_SLICE_OFFSET = 3'd5,
        CFG_STRIDE       = 3'd6
    } t_cfg_idx;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_START = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_NO_RANK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [POS_W-1:0]  entry_position;
        logic [RANK_W-1:0] entry_rank;
    } t_in_item;

    typedef struct packed {
        logic [STEP_W-1:0]  step_index;
        logic [RANK_W-1:0]  send_peer;
        logic [RANK_W-1:0]  recv_peer;
        logic [OFF_W-1:0]   tx_offset;
        logic [BYTES_W-1:0] tx_bytes;
        logic [CNT_W-1:0]   tx_elems;
        logic [OFF_W-1:0]   rx_offset;
        logic [BYTES_W-1:0] rx_bytes;
        logic [CNT_W-1:0]   rx_elems;
        logic               last_of_step;
        logic               last;
        logic               status;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/reduce_scatter_doubling_schedule.sv -----
// ----------------------------------------------------------------------------
// reduce_scatter_doubling_schedule: reduce-scatter transfer descriptor source
// Distance-doubling schedule built from a rank table, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_item): a load item writes one
//   rank table entry; a start item runs the schedule.
//   Output channel (o_out_valid / i_out_ready, o_out_item): descriptors in step
//   order, last set on the final one; a missing own rank gives one item with
//   status set. A start with one rank gives nothing.
//   Config channel (i_cfg_valid / o_cfg_ready): always ready, write while idle.
// Sequence of a start with n ranks:
//   table search reads up to n entries (one table read per cycle), then
//   each step sets up and reads its peers, and each descriptor runs table read,
//   tx id * stride, rx id * stride, emit. The single multiplier and the two
//   table read ports set this order; one descriptor runs at a time.
//   The block is busy during a start and takes the next item once the last
//   result sits in the output register.
// Reset: idles the sequencer, clears output valid, sets rank count and element
//   bytes to 1 and other config to 0; the rank table is undefined until written.
// Stall: a stalled output register holds its item and the sequencer waits.
// ----------------------------------------------------------------------------
`default_nettype none

module reduce_scatter_doubling_schedule #(
    parameter int MAX_RANKS    = rsds_pkg::MAX_RANKS_DEF,
    parameter int RANK_ID_BITS = rsds_pkg::RANK_ID_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  rsds_pkg::t_in_item                   i_in_item,
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output rsds_pkg::t_out_item                  o_out_item,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire [rsds_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire [rsds_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int ID_W  = RANK_ID_BITS;
    localparam int PW    = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam int NW    = $clog2(MAX_RANKS + 1);
    localparam int DW    = NW + 1;
    localparam int MULW  = ID_W + rsds_pkg::CNT_W;
    localparam int PRW   = (MULW > rsds_pkg::OFF_W) ? rsds_pkg::OFF_W : MULW;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_ERR,
        ST_STEP_SETUP,
        ST_STEP_RD,
        ST_SLICE_RD,
        ST_MUL_TX,
        ST_MUL_RX,
        ST_EMIT
    } t_state;

    // reduce x (below 2n) into 0 .. n-1
    function automatic logic [PW-1:0] f_wrap(input logic [DW-1:0] x,
                                             input logic [NW-1:0] n);
        logic [DW-1:0] y;
        y = (x >= DW'(n)) ? (x - DW'(n)) : x;
        return PW'(y);
    endfunction

    t_state                      r_state;

    // configuration
    logic [rsds_pkg::RCNT_W-1:0] r_rank_count;
    logic [rsds_pkg::RANK_W-1:0] r_my_rank;
    logic [rsds_pkg::CNT_W-1:0]  r_slice_count;
    logic [rsds_pkg::CNT_W-1:0]  r_tail_count;
    logic [rsds_pkg::EB_W-1:0]   r_elem_bytes;
    logic [rsds_pkg::BASE_W-1:0] r_slice_offset;
    logic [rsds_pkg::CNT_W-1:0]  r_stride;

    // rank table
    logic [ID_W-1:0]             mem [MAX_RANKS];
    logic [PW-1:0]               rd_addr_a;
    logic [PW-1:0]               rd_addr_b;
    logic [ID_W-1:0]             r_rdata_a;
    logic [ID_W-1:0]             r_rdata_b;

    // sequencer
    logic [NW-1:0]               r_n;
    logic [ID_W-1:0]             r_me;
    logic [NW-1:0]               r_k;
    logic                        r_cmp_vld;
    logic [PW-1:0]               r_cmp_pos;
    logic [PW-1:0]               r_p;
    logic [rsds_pkg::STEP_W-1:0] r_s;
    logic [PW-1:0]               r_to;
    logic [PW-1:0]               r_from;
    logic [PW-1:0]               r_back;
    logic [PW-1:0]               r_txp;
    logic [PW-1:0]               r_rxp;
    logic [NW-1:0]               r_left;
    logic                        r_final_step;
    logic                        r_first;
    logic [ID_W-1:0]             r_send_id;
    logic [ID_W-1:0]             r_recv_id;
    logic [PRW-1:0]              r_prod;
    logic [rsds_pkg::OFF_W-1:0]  r_tx_off;

    logic                        r_out_valid;
    rsds_pkg::t_out_item         r_out;

    logic                        in_acc;
    logic                        cfg_acc;
    logic                        out_free;
    logic [NW-1:0]               n_sat;
    logic [rsds_pkg::EB_W-1:0]   eb_clamp;
    logic [ID_W-1:0]             mul_a;
    logic [MULW-1:0]             mul_full;
    logic [DW-1:0]               d_val;
    logic [DW-1:0]               span_val;
    logic [DW-1:0]               slices_val;
    logic [PW-1:0]               last_pos;
    logic [rsds_pkg::CNT_W-1:0]  tx_cnt;
    logic [rsds_pkg::CNT_W-1:0]  rx_cnt;
    rsds_pkg::t_out_item         err_item;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign in_acc   = i_in_valid && o_in_ready;
    assign cfg_acc  = i_cfg_valid;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        if (r_rank_count == '0) begin
            n_sat = NW'(1);
        end else if (int'(r_rank_count) > MAX_RANKS) begin
            n_sat = NW'(MAX_RANKS);
        end else begin
            n_sat = NW'(r_rank_count);
        end
        if (r_elem_bytes == '0) begin
            eb_clamp = rsds_pkg::EB_W'(1);
        end else if (r_elem_bytes > rsds_pkg::EB_W'(8)) begin
            eb_clamp = rsds_pkg::EB_W'(8);
        end else begin
            eb_clamp = r_elem_bytes;
        end
    end

    // lone final item for a start whose own rank is missing
    always_comb begin
        err_item        = '0;
        err_item.last   = 1'b1;
        err_item.status = rsds_pkg::STATUS_NO_RANK;
    end

    // table read addresses: tx / rx positions unless searching or fetching peers
    always_comb begin
        rd_addr_a = r_txp;
        rd_addr_b = r_rxp;
        case (r_state)
            ST_SEARCH: begin
                rd_addr_a = r_k[PW-1:0];
            end
            ST_STEP_RD: begin
                rd_addr_a = r_to;
                rd_addr_b = r_from;
            end
            default: begin
            end
        endcase
    end

    // shared multiplier: rank id times stride
    assign mul_a    = (r_state == ST_MUL_TX) ? r_rdata_a : r_rdata_b;
    assign mul_full = MULW'(mul_a) * MULW'(r_stride);

    assign d_val      = DW'(1) << r_s;
    assign span_val   = DW'(2) << r_s;
    assign slices_val = (DW'(r_n) - DW'(1) + d_val) >> (r_s + rsds_pkg::STEP_W'(1));
    assign last_pos   = PW'(r_n - NW'(1));
    assign tx_cnt     = (r_txp == last_pos && r_tail_count != '0) ? r_tail_count
                                                                  : r_slice_count;
    assign rx_cnt     = (r_rxp == last_pos && r_tail_count != '0) ? r_tail_count
                                                                  : r_slice_count;

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_item.req_type == rsds_pkg::REQ_LOAD &&
            int'(i_in_item.entry_position) < MAX_RANKS) begin
            mem[i_in_item.entry_position[PW-1:0]] <= ID_W'(i_in_item.entry_rank);
        end
        r_rdata_a <= mem[rd_addr_a];
        r_rdata_b <= mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_out_valid    <= 1'b0;
            r_rank_count   <= rsds_pkg::RCNT_W'(1);
            r_my_rank      <= '0;
            r_slice_count  <= '0;
            r_tail_count   <= '0;
            r_elem_bytes   <= rsds_pkg::EB_W'(1);
            r_slice_offset <= '0;
            r_stride       <= '0;
        end else begin
            if (cfg_acc) begin
                case (rsds_pkg::t_cfg_idx'(i_cfg_index))
                    rsds_pkg::CFG_RANK_COUNT:
                        r_rank_count <= i_cfg_data[rsds_pkg::RCNT_W-1:0];
                    rsds_pkg::CFG_MY_RANK:
                        r_my_rank <= i_cfg_data[rsds_pkg::RANK_W-1:0];
                    rsds_pkg::CFG_SLICE_COUNT:
                        r_slice_count <= i_cfg_data[rsds_pkg::CNT_W-1:0];
                    rsds_pkg::CFG_TAIL_COUNT:
                        r_tail_count <= i_cfg_data[rsds_pkg::CNT_W-1:0];
                    rsds_pkg::CFG_ELEM_BYTES:
                        r_elem_bytes <= i_cfg_data[rsds_pkg::EB_W-1:0];
                    rsds_pkg::CFG_SLICE_OFFSET:
                        r_slice_offset <= i_cfg_data[rsds_pkg::BASE_W-1:0];
                    rsds_pkg::CFG_STRIDE:
                        r_stride <= i_cfg_data[rsds_pkg::CNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (out_free && (r_state == ST_EMIT || r_state == ST_ERR)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (in_acc && i_in_item.req_type == rsds_pkg::REQ_START &&
                        n_sat > NW'(1)) begin
                        r_n       <= n_sat;
                        r_me      <= ID_W'(r_my_rank);
                        r_k       <= '0;
                        r_cmp_vld <= 1'b0;
                        r_state   <= ST_SEARCH;
                    end
                end
                ST_SEARCH: begin
                    // issue one position per cycle, compare the one read last cycle
                    if (r_k < r_n) begin
                        r_k       <= r_k + NW'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_pos <= r_k[PW-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                    end
                    if (r_cmp_vld && r_rdata_a == r_me) begin
                        r_p     <= r_cmp_pos;
                        r_s     <= '0;
                        r_state <= ST_STEP_SETUP;
                    end else if (r_cmp_vld && r_cmp_pos == last_pos) begin
                        r_state <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (out_free) begin
                        r_out   <= err_item;
                        r_state <= ST_IDLE;
                    end
                end
                ST_STEP_SETUP: begin
                    r_to         <= f_wrap(DW'(r_p) + DW'(r_n) - d_val, r_n);
                    r_from       <= f_wrap(DW'(r_p) + d_val, r_n);
                    r_back       <= f_wrap(span_val, r_n);
                    r_txp        <= f_wrap(DW'(r_p) + DW'(r_n) - d_val, r_n);
                    r_rxp        <= r_p;
                    r_left       <= NW'(slices_val);
                    r_final_step <= (span_val >= DW'(r_n));
                    r_state      <= ST_STEP_RD;
                end
                ST_STEP_RD: begin
                    r_first <= 1'b1;
                    r_state <= ST_SLICE_RD;
                end
                ST_SLICE_RD: begin
                    if (r_first) begin
                        r_send_id <= r_rdata_a;
                        r_recv_id <= r_rdata_b;
                    end
                    r_first <= 1'b0;
                    r_state <= ST_MUL_TX;
                end
                ST_MUL_TX: begin
                    r_prod  <= PRW'(mul_full);
                    r_state <= ST_MUL_RX;
                end
                ST_MUL_RX: begin
                    r_prod   <= PRW'(mul_full);
                    r_tx_off <= rsds_pkg::OFF_W'(r_slice_offset) + rsds_pkg::OFF_W'(r_prod);
                    r_state  <= ST_EMIT;
                end
                ST_EMIT: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_out.step_index   <= r_s;
                        r_out.send_peer    <= rsds_pkg::RANK_W'(r_send_id);
                        r_out.recv_peer    <= rsds_pkg::RANK_W'(r_recv_id);
                        r_out.tx_offset    <= r_tx_off;
                        r_out.tx_bytes     <= rsds_pkg::BYTES_W'(
                            36'(tx_cnt) * 36'(eb_clamp));
                        r_out.tx_elems     <= tx_cnt;
                        r_out.rx_offset    <= rsds_pkg::OFF_W'(r_slice_offset) +
                                              rsds_pkg::OFF_W'(r_prod);
                        r_out.rx_bytes     <= rsds_pkg::BYTES_W'(
                            36'(rx_cnt) * 36'(eb_clamp));
                        r_out.rx_elems     <= rx_cnt;
                        r_out.last_of_step <= (r_left == NW'(1));
                        r_out.last         <= (r_left == NW'(1)) && r_final_step;
                        r_out.status       <= rsds_pkg::STATUS_OK;
                        // move both positions back by the span
                        r_txp  <= f_wrap(DW'(r_txp) + DW'(r_n) - DW'(r_back), r_n);
                        r_rxp  <= f_wrap(DW'(r_rxp) + DW'(r_n) - DW'(r_back), r_n);
                        r_left <= r_left - NW'(1);
                        if (r_left != NW'(1)) begin
                            r_state <= ST_SLICE_RD;
                        end else if (r_final_step) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_s     <= r_s + rsds_pkg::STEP_W'(1);
                            r_state <= ST_STEP_SETUP;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rsds_chk.sv -----
// ----------------------------------------------------------------------------
// rsds_chk: port-level checks for the reduce-scatter schedule block
// Watches the top level's ports; attached by the bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module rsds_chk (
    input wire                            i_clk,
    input wire                            i_rst_n,
    input wire                            o_in_ready,
    input wire                            o_out_valid,
    input wire                            i_out_ready,
    input rsds_pkg::t_out_item            o_out_item
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == rsds_pkg::STATUS_NO_RANK |->
            o_out_item.last && !o_out_item.last_of_step)
        else $error("error item not shaped as a lone final item");

    a_last_ends_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status == rsds_pkg::STATUS_OK && o_out_item.last
            |-> o_out_item.last_of_step)
        else $error("final descriptor does not close its step");

    // a pending non-final descriptor means the schedule is still running
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.last |-> !o_in_ready)
        else $error("input taken while a schedule is in progress");

endmodule

bind reduce_scatter_doubling_schedule rsds_chk u_rsds_chk (.*);

`default_nettype wire
